### sv/ttu_pkg.sv
// Shared types and constants for the transposition table unit.
package ttu_pkg;

	localparam int HASH_W  = 64;
	localparam int KOMI_W  = 16;
	localparam int VISIT_W = 32;
	localparam int SUM_W   = 48;
	localparam int LOW_W   = 32;
	localparam int STEP_W  = 6;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_SYNC   = 1'b1;

	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [VISIT_W-1:0] visits;
		logic [SUM_W-1:0]   sum;
	} entry_t;

	typedef struct packed {
		logic load;
		logic step;
		logic rd_en;
		logic wr_en;
		logic clr_en;
		logic res_load;
		logic komi_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic idx_done;
		logic is_sync;
		logic komi_diff;
		logic clr_last;
		logic out_free;
	} ctl_sts_t;

endpackage

### sv/transposition_table_unit.sv
// Top level of the transposition table unit: controller plus datapath.
//
// Direct-mapped transposition table of ENTRIES slots, each holding a 64-bit
// position hash, a 32-bit visit count and a 48-bit evaluation sum. A request
// picks slot (low 32 hash bits) mod ENTRIES. An update request (req_type 0)
// writes the slot; when its komi differs from the stored komi, the whole table
// is wiped instead (the fresh slot included) and the new komi is kept. A sync
// request (req_type 1) reports hit when the slot hash and stored komi match and
// the stored visits exceed node_visits, returning the stored visits and sum;
// otherwise all result fields are zero. Every request yields exactly one
// result. With ENTRIES a power of two a request reads the slot from the
// single-port table in the index state and compares and writes back in the
// compare state, which can already take the next request. For any other
// ENTRIES the slot number comes from a reciprocal-multiply remainder unit
// (estimate, multiply back, subtract and correct) before the read. A komi
// change on update starts a clearing sweep, one slot a cycle, during which
// in_stall is high; the same sweep runs after reset, so in_stall stays high
// from the release of arst_n until the sweep ends. The result sits in an
// output register: an idle block takes a new request while the previous
// result still waits on out_stall, but a request that reaches compare holds
// there until that result is taken.
module transposition_table_unit #(
	parameter int ENTRIES = 16384
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [ttu_pkg::HASH_W-1:0]         position_hash,
	input  logic signed [ttu_pkg::KOMI_W-1:0]  komi_value,
	input  logic [ttu_pkg::VISIT_W-1:0]        node_visits,
	input  logic [ttu_pkg::SUM_W-1:0]          node_eval_sum,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [ttu_pkg::VISIT_W-1:0]        visits_out,
	output logic [ttu_pkg::SUM_W-1:0]          eval_sum_out
);

	ttu_pkg::ctl_cmd_t cmd;
	ttu_pkg::ctl_sts_t sts;

	// sequencing: clear sweep, request take, index, read, compare/write
	ttu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// request registers, slot index, table memory, result register
	ttu_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.position_hash (position_hash),
		.komi_value    (komi_value),
		.node_visits   (node_visits),
		.node_eval_sum (node_eval_sum),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.visits_out    (visits_out),
		.eval_sum_out  (eval_sum_out)
	);

endmodule

### sv/ttu_ctrl.sv
// Controller state machine of the transposition table unit.
module ttu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ttu_pkg::ctl_sts_t sts,
	output ttu_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_INDEX = 4'b0100,
		ST_CMP   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_INDEX;
				end
			end
			ST_INDEX: begin
				// hold until the slot number is known, then read it
				cmd.step  = !sts.idx_done;
				cmd.rd_en = sts.idx_done;
				if (sts.idx_done) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					if (!sts.is_sync && sts.komi_diff) begin
						// komi changed: the whole table goes, the slot write with it
						cmd.komi_load = 1'b1;
						state_d       = ST_CLEAR;
					end else begin
						cmd.wr_en = !sts.is_sync;
						in_stall  = 1'b0;
						if (in_valid) begin
							cmd.load = 1'b1;
							state_d  = ST_INDEX;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (in_stall && !cmd.wr_en && !cmd.rd_en))
		else $error("request taken or slot touched during table clear");

	a_read_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> (state_q == ST_CMP))
		else $error("slot read not followed by compare");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && sts.clr_last) |=> (state_q == ST_IDLE))
		else $error("table clear did not finish on the last slot");
`endif

endmodule

### sv/ttu_dpath.sv
// Datapath of the transposition table unit: request registers, slot index, table, result.
module ttu_dpath #(
	parameter int ENTRIES = 16384
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ttu_pkg::ctl_cmd_t                  cmd,
	output ttu_pkg::ctl_sts_t                  sts,
	input  logic                               req_type,
	input  logic [ttu_pkg::HASH_W-1:0]         position_hash,
	input  logic signed [ttu_pkg::KOMI_W-1:0]  komi_value,
	input  logic [ttu_pkg::VISIT_W-1:0]        node_visits,
	input  logic [ttu_pkg::SUM_W-1:0]          node_eval_sum,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic [ttu_pkg::VISIT_W-1:0]        visits_out,
	output logic [ttu_pkg::SUM_W-1:0]          eval_sum_out
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam bit IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

	logic                         req_type_q;
	logic [ttu_pkg::HASH_W-1:0]   hash_q;
	logic [ttu_pkg::KOMI_W-1:0]   komi_q;
	logic [ttu_pkg::VISIT_W-1:0]  visits_q;
	logic [ttu_pkg::SUM_W-1:0]    sum_q;
	logic [ttu_pkg::KOMI_W-1:0]   stored_komi_q;
	logic [IW-1:0]                idx;
	logic                         idx_done;
	logic [IW-1:0]                clr_cnt_q;
	logic                         clr_last;

	ttu_pkg::entry_t mem [ENTRIES];
	ttu_pkg::entry_t rd_q;
	ttu_pkg::entry_t wr_data;
	logic [IW-1:0]   wr_addr;

	logic                         out_valid_q;
	logic                         hit_q;
	logic [ttu_pkg::VISIT_W-1:0]  visits_out_q;
	logic [ttu_pkg::SUM_W-1:0]    eval_sum_out_q;
	logic                         match;

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			hash_q     <= position_hash;
			komi_q     <= komi_value;
			visits_q   <= node_visits;
			sum_q      <= node_eval_sum;
		end
	end

	// slot index: low 32 hash bits modulo ENTRIES
	if (IS_POW2) begin : g_pow2
		localparam logic [ttu_pkg::LOW_W-1:0] IDX_MASK = ttu_pkg::LOW_W'(ENTRIES - 1);
		assign idx      = IW'(hash_q[ttu_pkg::LOW_W-1:0] & IDX_MASK);
		assign idx_done = 1'b1;
	end else begin : g_mod
		// quotient estimate by reciprocal is low by at most one, so one correction
		localparam logic [ttu_pkg::LOW_W-1:0] RECIP =
			ttu_pkg::LOW_W'((64'd1 << ttu_pkg::LOW_W) / 64'(ENTRIES));
		localparam logic [ttu_pkg::LOW_W-1:0] DIVISOR = ttu_pkg::LOW_W'(ENTRIES);
		localparam int IDX_STEPS = 3;
		logic [2*ttu_pkg::LOW_W-1:0] prod;
		logic [ttu_pkg::LOW_W-1:0]   quo_q;
		logic [ttu_pkg::LOW_W-1:0]   back_q;
		logic [ttu_pkg::LOW_W-1:0]   diff;
		logic [IW-1:0]               rem_q;
		logic [ttu_pkg::STEP_W-1:0]  step_q;

		assign prod = (2*ttu_pkg::LOW_W)'(hash_q[ttu_pkg::LOW_W-1:0]) *
		              (2*ttu_pkg::LOW_W)'(RECIP);
		assign diff = hash_q[ttu_pkg::LOW_W-1:0] - back_q;

		// three steps: estimate, multiply back, subtract and correct
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				quo_q  <= '0;
				back_q <= '0;
				rem_q  <= '0;
				step_q <= '0;
			end else if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.step) begin
				quo_q  <= prod[2*ttu_pkg::LOW_W-1:ttu_pkg::LOW_W];
				back_q <= quo_q * DIVISOR;
				rem_q  <= (diff >= DIVISOR) ? IW'(diff - DIVISOR) : IW'(diff);
				step_q <= step_q + 1'b1;
			end
		end

		assign idx      = rem_q;
		assign idx_done = (step_q == ttu_pkg::STEP_W'(IDX_STEPS));
	end

	// clearing sweep, one slot a cycle
	assign clr_last = (clr_cnt_q == IW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_komi_q <= '0;
		end else if (cmd.komi_load) begin
			stored_komi_q <= komi_q;
		end
	end

	// table memory
	assign wr_addr = cmd.clr_en ? clr_cnt_q : idx;
	always_comb begin
		wr_data = '0;
		if (!cmd.clr_en) begin
			wr_data.hash   = hash_q;
			wr_data.visits = visits_q;
			wr_data.sum    = sum_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en || cmd.clr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[idx];
		end
	end

	// compare and result register
	assign match = (rd_q.hash == hash_q) && (stored_komi_q == komi_q) &&
	               (rd_q.visits > visits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			hit_q          <= req_type_q && match;
			visits_out_q   <= (req_type_q && match) ? rd_q.visits : '0;
			eval_sum_out_q <= (req_type_q && match) ? rd_q.sum : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign visits_out   = visits_out_q;
	assign eval_sum_out = eval_sum_out_q;

	assign sts.idx_done  = idx_done;
	assign sts.is_sync   = (req_type_q == ttu_pkg::REQ_SYNC);
	assign sts.komi_diff = (komi_q != stored_komi_q);
	assign sts.clr_last  = clr_last;
	assign sts.out_free  = !out_valid_q || !out_stall;

`ifndef SYNTHESIS
	a_hit_has_visits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && hit_q) |-> (visits_out_q != '0))
		else $error("hit reported with zero stored visits");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the transposition table unit: random and directed requests.
module tb_top;

	localparam int TABLE_SLOTS = 16384;
	// The longest quiet stretch in a correct run is one clearing sweep plus a long gap
	// on each side. Allow several times that before declaring the block hung.
	localparam int QUIET_LIMIT = 4 * TABLE_SLOTS + 4000;
	localparam int RANDOM_REQUESTS = 1600;

	typedef struct packed {
		logic                        kind;
		logic [ttu_pkg::HASH_W-1:0]  hash;
		logic [ttu_pkg::KOMI_W-1:0]  komi;
		logic [ttu_pkg::VISIT_W-1:0] visits;
		logic [ttu_pkg::SUM_W-1:0]   sum;
	} request_t;

	typedef struct packed {
		logic                        hit;
		logic [ttu_pkg::VISIT_W-1:0] visits;
		logic [ttu_pkg::SUM_W-1:0]   sum;
	} reply_t;

	// Shadow copy of the table. Slots absent from the associative array read as zero,
	// which matches both the reset state and the state after a komi-change wipe.
	class table_mirror;
		ttu_pkg::entry_t            slots [int unsigned];
		logic [ttu_pkg::KOMI_W-1:0] komi_now;
		reply_t                     replies [$];
		int unsigned                errors;

		function new();
			komi_now = '0;
			errors = 0;
		endfunction

		function ttu_pkg::entry_t lookup(logic [ttu_pkg::HASH_W-1:0] h);
			int unsigned idx;
			idx = h[ttu_pkg::LOW_W-1:0] % TABLE_SLOTS;
			if (slots.exists(idx))
				return slots[idx];
			return '0;
		endfunction

		// Apply one accepted request to the shadow table and queue its expected reply.
		function void apply_request(request_t rq);
			int unsigned     idx;
			ttu_pkg::entry_t e;
			reply_t          r;
			idx = rq.hash[ttu_pkg::LOW_W-1:0] % TABLE_SLOTS;
			e = lookup(rq.hash);
			r = '0;
			if (rq.kind == ttu_pkg::REQ_UPDATE) begin
				slots[idx] = '{hash: rq.hash, visits: rq.visits, sum: rq.sum};
				// A new komi wipes everything, the slot just written included.
				if (rq.komi != komi_now) begin
					slots.delete();
					komi_now = rq.komi;
				end
			end else if (e.hash == rq.hash && komi_now == rq.komi && e.visits > rq.visits) begin
				r.hit = 1'b1;
				r.visits = e.visits;
				r.sum = e.sum;
			end
			replies.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expected reply.
		function void check_reply(logic h, logic [ttu_pkg::VISIT_W-1:0] v,
			logic [ttu_pkg::SUM_W-1:0] s);
			reply_t r;
			if (replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: result with no request pending: hit=%b visits=%h sum=%h",
						h, v, s);
				return;
			end
			r = replies.pop_front();
			if (r.hit !== h || r.visits !== v || r.sum !== s) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: hit exp %b got %b, visits exp %h got %h, sum exp %h got %h",
						r.hit, h, r.visits, v, r.sum, s);
			end
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic                        req_type = ttu_pkg::REQ_UPDATE;
	logic [ttu_pkg::HASH_W-1:0]  position_hash = '0;
	logic [ttu_pkg::KOMI_W-1:0]  komi_value = '0;
	logic [ttu_pkg::VISIT_W-1:0] node_visits = '0;
	logic [ttu_pkg::SUM_W-1:0]   node_eval_sum = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        hit;
	logic [ttu_pkg::VISIT_W-1:0] visits_out;
	logic [ttu_pkg::SUM_W-1:0]   eval_sum_out;

	table_mirror mirror = new();
	// When set, both sides run flat out with no gaps and no stalls.
	bit calm = 1'b0;
	logic [ttu_pkg::HASH_W-1:0] known [$];

	transposition_table_unit #(
		.ENTRIES(TABLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position_hash(position_hash),
		.komi_value(komi_value),
		.node_visits(node_visits),
		.node_eval_sum(node_eval_sum),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.visits_out(visits_out),
		.eval_sum_out(eval_sum_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	function automatic logic [ttu_pkg::HASH_W-1:0] random_hash();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ttu_pkg::SUM_W-1:0] random_sum();
		return ttu_pkg::SUM_W'({$urandom, $urandom} >> 16);
	endfunction

	// Present one request, hold it until accepted, then update the mirror.
	task automatic issue(input logic kind, input logic [ttu_pkg::HASH_W-1:0] h,
		input logic [ttu_pkg::KOMI_W-1:0] k, input logic [ttu_pkg::VISIT_W-1:0] v,
		input logic [ttu_pkg::SUM_W-1:0] s);
		request_t    rq;
		int unsigned gap;
		rq = '{kind: kind, hash: h, komi: k, visits: v, sum: s};
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		position_hash <= h;
		komi_value <= k;
		node_visits <= v;
		node_eval_sum <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		mirror.apply_request(rq);
	endtask

	// Random update: fresh hash, overwrite of a known hash, or a slot collision.
	// Rarely change komi, which wipes the table.
	task automatic random_update();
		logic [ttu_pkg::HASH_W-1:0]  h;
		logic [ttu_pkg::KOMI_W-1:0]  k;
		logic [ttu_pkg::VISIT_W-1:0] v;
		int unsigned                 r;
		r = $urandom_range(99);
		h = random_hash();
		if (known.size() != 0 && r < 25)
			h = known[$urandom_range(known.size() - 1)];
		else if (known.size() != 0 && r < 50)
			h[ttu_pkg::LOW_W-1:0] = known[$urandom_range(known.size() - 1)][ttu_pkg::LOW_W-1:0];
		k = mirror.komi_now;
		if ($urandom_range(999) < 15)
			k = ttu_pkg::KOMI_W'($urandom);
		v = ($urandom_range(3) == 0) ? ttu_pkg::VISIT_W'($urandom_range(20)) :
			ttu_pkg::VISIT_W'($urandom);
		issue(ttu_pkg::REQ_UPDATE, h, k, v, random_sum());
		if (k != mirror.komi_now || mirror.slots.size() == 0)
			known.delete();
		else begin
			known.push_back(h);
			if (known.size() > 64)
				void'(known.pop_front());
		end
	endtask

	// Well-formed sync: look up a known hash with the current komi, mostly below
	// the stored visits so that it hits.
	task automatic random_sync();
		logic [ttu_pkg::HASH_W-1:0]  h;
		logic [ttu_pkg::VISIT_W-1:0] v;
		ttu_pkg::entry_t             e;
		int unsigned                 r;
		h = (known.size() != 0) ? known[$urandom_range(known.size() - 1)] : random_hash();
		e = mirror.lookup(h);
		r = $urandom_range(99);
		if (e.visits != 0 && r < 70)
			v = $urandom_range(e.visits - 1);
		else if (r < 85)
			v = e.visits;
		else
			v = $urandom;
		issue(ttu_pkg::REQ_SYNC, h, mirror.komi_now, v, random_sum());
	endtask

	// Noise: syncs with a wrong komi, a wrong upper hash, or hash zero.
	task automatic random_noise();
		logic [ttu_pkg::HASH_W-1:0] h;
		logic [ttu_pkg::KOMI_W-1:0] k;
		int unsigned                r;
		r = $urandom_range(99);
		h = random_hash();
		k = mirror.komi_now;
		if (r < 40)
			k = ttu_pkg::KOMI_W'($urandom);
		else if (r < 70 && known.size() != 0)
			h[ttu_pkg::LOW_W-1:0] = known[$urandom_range(known.size() - 1)][ttu_pkg::LOW_W-1:0];
		else if (r < 80)
			h = '0;
		issue(ttu_pkg::REQ_SYNC, h, k, $urandom, random_sum());
	endtask

	// Result side: check each accepted result, then pick the next stall pattern.
	initial begin
		int unsigned stall_left;
		int unsigned r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				mirror.check_reply(hit, visits_out, eval_sum_out);
			if (stall_left != 0 && !calm) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = 0;
				r = $urandom_range(99);
				if (!calm && r < 20)
					stall_left = $urandom_range(3, 1);
				else if (!calm && r < 23)
					stall_left = $urandom_range(60, 10);
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("transposition_table_unit regression: fail");
		$finish;
	end

	initial begin
		logic [ttu_pkg::HASH_W-1:0] h_max;
		logic [ttu_pkg::HASH_W-1:0] h_b;
		logic [ttu_pkg::HASH_W-1:0] h_c;
		int unsigned                r;
		h_max = '1;
		h_b = 64'h0123_4567_89AB_CDEF;
		h_c = 64'hFEDC_BA98_7654_3210;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: cleared slot never hits, even on hash zero.
		issue(ttu_pkg::REQ_SYNC, '0, '0, '0, '0);
		// Extremes of every field, then hit, equal-visits miss, wrong komi, wrong upper hash.
		issue(ttu_pkg::REQ_UPDATE, h_max, '0, '1, '1);
		issue(ttu_pkg::REQ_SYNC, h_max, '0, '0, '0);
		issue(ttu_pkg::REQ_SYNC, h_max, '0, '1, '0);
		issue(ttu_pkg::REQ_SYNC, h_max, 16'h8000, '0, '0);
		issue(ttu_pkg::REQ_SYNC, {32'h0, 32'hFFFF_FFFF}, '0, '0, '0);
		// Hash zero written with real data does hit.
		issue(ttu_pkg::REQ_UPDATE, '0, '0, 32'd1, '0);
		issue(ttu_pkg::REQ_SYNC, '0, '0, '0, '1);
		// Komi change on update: table wiped, the fresh slot included.
		issue(ttu_pkg::REQ_UPDATE, h_b, 16'h8000, 32'd5, 48'd123);
		issue(ttu_pkg::REQ_SYNC, h_max, 16'h8000, '0, '0);
		issue(ttu_pkg::REQ_SYNC, h_b, 16'h8000, '0, '0);
		issue(ttu_pkg::REQ_UPDATE, h_b, 16'h8000, 32'd5, 48'd123);
		issue(ttu_pkg::REQ_SYNC, h_b, 16'h8000, 32'd4, '0);
		issue(ttu_pkg::REQ_SYNC, h_b, 16'h0000, 32'd4, '0);
		// Other komi extreme, mid-scale visits and sum.
		issue(ttu_pkg::REQ_UPDATE, h_c, 16'h7FFF, '0, '0);
		issue(ttu_pkg::REQ_UPDATE, h_c, 16'h7FFF, 32'h8000_0000, 48'h8000_0000_0000);
		issue(ttu_pkg::REQ_SYNC, h_c, 16'h7FFF, 32'h7FFF_FFFF, '0);
		issue(ttu_pkg::REQ_UPDATE, h_c, 16'h7FFF, '0, '1);
		issue(ttu_pkg::REQ_SYNC, h_c, 16'h7FFF, '0, '0);
		// Back to komi zero for the random part.
		issue(ttu_pkg::REQ_UPDATE, random_hash(), '0, $urandom, '0);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 150 == 0)
				calm = ($urandom_range(3) == 0);
			r = $urandom_range(99);
			if (r < 40)
				random_update();
			else if (r < 85)
				random_sync();
			else
				random_noise();
		end
		in_valid <= 1'b0;

		// Drain: every queued reply must arrive, then watch a little longer for extras.
		while (mirror.replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mirror.errors == 0)
			$display("transposition_table_unit regression: pass");
		else
			$display("transposition_table_unit regression: fail");
		$finish;
	end

endmodule

### files.f
sv/ttu_pkg.sv
sv/ttu_ctrl.sv
sv/ttu_dpath.sv
sv/transposition_table_unit.sv
tb/tb_top.sv
